// ===== hdl/binary_to_decimal_ascii_unit_assert.svh =====
// Assertion macros for the binary to decimal ASCII unit.
// Used by the top level only; no other dependencies.
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`ifndef SYNTH
`define BTDA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("btda assertion failed");
`define BTDA_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("btda forbidden condition seen");
`else
`define BTDA_ASSERT(label, clk, rst_n, prop)
`define BTDA_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hdl/btda_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII unit.
// No dependencies.
package btda_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_W-1:0] DIGIT_FIVE  = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_THREE = 4'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_BIT,
    CELL_DIGIT
  } cell_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/btda_cell.sv =====
// One decimal digit cell of the shift-and-add-three chain.
// Depends on btda_pkg.
module btda_cell (
  input  logic                         clk,
  input  btda_pkg::cell_mode_t         mode,
  input  logic                         bit_in,
  input  logic [btda_pkg::DIGIT_W-1:0] digit_in,
  output logic                         bit_out,
  output logic [btda_pkg::DIGIT_W-1:0] digit_q
);

  logic [btda_pkg::DIGIT_W-1:0] digit_r;
  logic [btda_pkg::DIGIT_W-1:0] digit_nxt;
  logic [btda_pkg::DIGIT_W-1:0] adj;

  assign adj     = (digit_r >= btda_pkg::DIGIT_FIVE) ? digit_r + btda_pkg::DIGIT_THREE
                                                     : digit_r;
  assign bit_out = adj[btda_pkg::DIGIT_W-1];
  assign digit_q = digit_r;

  always_comb begin
    unique case (mode)
      btda_pkg::CELL_HOLD:  digit_nxt = digit_r;
      btda_pkg::CELL_CLEAR: digit_nxt = '0;
      btda_pkg::CELL_BIT:   digit_nxt = {adj[btda_pkg::DIGIT_W-2:0], bit_in};
      btda_pkg::CELL_DIGIT: digit_nxt = digit_in;
      default:              digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

// ===== hdl/binary_to_decimal_ascii_unit.sv =====
// Top level of the binary to decimal ASCII unit: control and cell chain.
// Depends on btda_pkg, btda_cell and binary_to_decimal_ascii_unit_assert.svh.
//
// Channel  Direction  Ports                              Meaning
// in       input      in_valid, in_stall, in_value       one number per request
// out      output     out_valid, out_stall, out_digit_char, out_last
//                                                        one ASCII digit per request
//
// A number is loaded while the digit cells clear, then shifted in bit by bit, INPUT_WIDTH
// bits in all; then MAX_DIGITS digit positions follow, each a suppressed leading zero or
// an emitted digit, and an output stall holds back an emitted digit.
// Reset is synchronous and returns control to idle; the cells need no reset.
// A new number is taken once the previous one has sent its last digit to the
// output register.
`include "binary_to_decimal_ascii_unit_assert.svh"

module binary_to_decimal_ascii_unit #(
  parameter int unsigned INPUT_WIDTH = 32,
  parameter int unsigned MAX_DIGITS  = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [INPUT_WIDTH-1:0]        in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [btda_pkg::CHAR_W-1:0]   out_digit_char,
  output logic                          out_last
);

  localparam int unsigned BW = $clog2(INPUT_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_DIGITS + 1);
  localparam logic [BW-1:0] BIT_ONE   = BW'(1);
  localparam logic [BW-1:0] BIT_FULL  = BW'(INPUT_WIDTH);
  localparam logic [RW-1:0] REM_ONE   = RW'(1);
  localparam logic [RW-1:0] REM_FULL  = RW'(MAX_DIGITS);

  btda_pkg::state_t     state_r, state_nxt;
  btda_pkg::cell_mode_t cell_mode;

  logic [INPUT_WIDTH-1:0] value_r;
  logic [BW-1:0]          bit_cnt_r;
  logic [RW-1:0]          rem_r;
  logic                   lead_r;
  logic                   out_valid_r;
  logic [btda_pkg::CHAR_W-1:0] out_char_r;
  logic                   out_last_r;

  logic in_take;
  logic out_free;
  logic emit_skip;
  logic emit_send;
  logic char_ok;

  logic [MAX_DIGITS-1:0]       carry;
  logic [btda_pkg::DIGIT_W-1:0] digits [MAX_DIGITS];
  logic [btda_pkg::DIGIT_W-1:0] top_digit;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_DIGITS; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        btda_cell u_cell (
          .clk      (clk),
          .mode     (cell_mode),
          .bit_in   (value_r[INPUT_WIDTH-1]),
          .digit_in ('0),
          .bit_out  (carry[gi]),
          .digit_q  (digits[gi])
        );
      end else begin : g_next
        btda_cell u_cell (
          .clk      (clk),
          .mode     (cell_mode),
          .bit_in   (carry[gi-1]),
          .digit_in (digits[gi-1]),
          .bit_out  (carry[gi]),
          .digit_q  (digits[gi])
        );
      end
    end
  endgenerate

  assign top_digit = digits[MAX_DIGITS-1];
  assign in_stall  = (state_r != btda_pkg::ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_skip = (state_r == btda_pkg::ST_EMIT) && lead_r && (top_digit == '0)
                     && (rem_r > REM_ONE);
  assign emit_send = (state_r == btda_pkg::ST_EMIT) && !emit_skip && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      btda_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = btda_pkg::ST_CONV;
      end
      btda_pkg::ST_CONV: begin
        if (bit_cnt_r == BIT_ONE) state_nxt = btda_pkg::ST_EMIT;
      end
      btda_pkg::ST_EMIT: begin
        if (emit_send && (rem_r == REM_ONE)) state_nxt = btda_pkg::ST_IDLE;
      end
      default: state_nxt = btda_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cell_mode = btda_pkg::CELL_HOLD;
    unique case (state_r)
      btda_pkg::ST_IDLE: begin
        if (in_take) cell_mode = btda_pkg::CELL_CLEAR;
      end
      btda_pkg::ST_CONV: cell_mode = btda_pkg::CELL_BIT;
      btda_pkg::ST_EMIT: begin
        if (emit_skip || emit_send) cell_mode = btda_pkg::CELL_DIGIT;
      end
      default: cell_mode = btda_pkg::CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= btda_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      rem_r       <= '0;
      lead_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_take) begin
        bit_cnt_r <= BIT_FULL;
      end else if (state_r == btda_pkg::ST_CONV) begin
        bit_cnt_r <= bit_cnt_r - BIT_ONE;
      end
      if ((state_r == btda_pkg::ST_CONV) && (bit_cnt_r == BIT_ONE)) begin
        rem_r  <= REM_FULL;
        lead_r <= 1'b1;
      end else if (emit_skip) begin
        rem_r <= rem_r - REM_ONE;
      end else if (emit_send) begin
        rem_r  <= rem_r - REM_ONE;
        lead_r <= 1'b0;
      end
      if (emit_send) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      value_r <= in_value;
    end else if (state_r == btda_pkg::ST_CONV) begin
      value_r <= {value_r[INPUT_WIDTH-2:0], 1'b0};
    end
    if (emit_send) begin
      out_char_r <= btda_pkg::ASCII_ZERO | {2'b00, top_digit};
      out_last_r <= (rem_r == REM_ONE);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;

  assign char_ok = (out_char_r[5:4] == 2'b11) && (out_char_r[3:0] <= 4'd9);

  `BTDA_ASSERT(a_take_starts_conv, clk, rst_n, in_take |=> (state_r == btda_pkg::ST_CONV))
  `BTDA_ASSERT_NEVER(a_emit_rem_nonzero, clk, rst_n, (state_r == btda_pkg::ST_EMIT) && (rem_r == '0))
  `BTDA_ASSERT_NEVER(a_conv_cnt_nonzero, clk, rst_n, (state_r == btda_pkg::ST_CONV) && (bit_cnt_r == '0))
  `BTDA_ASSERT(a_char_is_digit, clk, rst_n, out_valid_r |-> char_ok)

endmodule

// ===== sim/binary_to_decimal_ascii_unit_checker.sv =====
// Checker for the binary to decimal ASCII unit: watches both channels, predicts
// the digit text of every accepted number and compares it with the output.
// Depends on btda_pkg.
`timescale 1ns / 100ps

module binary_to_decimal_ascii_unit_checker #(
  parameter int unsigned INPUT_WIDTH = 32,
  parameter int unsigned MAX_DIGITS  = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [INPUT_WIDTH-1:0]      in_value,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [btda_pkg::CHAR_W-1:0] out_digit_char,
  input  logic                        out_last,
  output int                          error_count,
  output int                          digits_pending,
  output int                          numbers_taken,
  output int                          digits_checked
);

  typedef struct packed {
    logic [btda_pkg::CHAR_W-1:0] digit_char;
    logic                        last;
  } digit_t;

  digit_t digit_queue[$];

  initial begin
    error_count    = 0;
    digits_pending = 0;
    numbers_taken  = 0;
    digits_checked = 0;
  end

  function automatic void queue_decimal_digits(input logic [INPUT_WIDTH-1:0] value);
    logic [btda_pkg::DIGIT_W-1:0] digits [MAX_DIGITS];
    logic [INPUT_WIDTH-1:0]       rest;
    int                           top;
    digit_t                       entry;
    rest = value;
    top  = 0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      digits[i] = btda_pkg::DIGIT_W'(rest % 10);
      rest      = rest / 10;
      if (digits[i] != 0) top = i;
    end
    for (int i = top; i >= 0; i--) begin
      entry.digit_char = btda_pkg::ASCII_ZERO + btda_pkg::CHAR_W'(digits[i]);
      entry.last       = (i == 0);
      digit_queue.push_back(entry);
    end
  endfunction

  always @(posedge clk) begin : watch
    digit_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        queue_decimal_digits(in_value);
        numbers_taken++;
      end
      if (out_valid && !out_stall) begin
        digits_checked++;
        if (digit_queue.size() == 0) begin
          $display("%0t: unexpected digit, char %0d last %0b", $time, out_digit_char,
                   out_last);
          error_count++;
        end else begin
          want = digit_queue.pop_front();
          if (out_digit_char !== want.digit_char) begin
            $display("%0t: digit char expected %0d, actual %0d", $time, want.digit_char,
                     out_digit_char);
            error_count++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last mark expected %0b, actual %0b", $time, want.last,
                     out_last);
            error_count++;
          end
        end
      end
      digits_pending = digit_queue.size();
    end
  end

endmodule

// ===== sim/binary_to_decimal_ascii_unit_test.sv =====
// Testbench top for the binary to decimal ASCII unit: clock, reset, number
// requests, output stalls and the verdict. Depends on btda_pkg, the unit and
// binary_to_decimal_ascii_unit_checker.
`timescale 1ns / 100ps

module binary_to_decimal_ascii_unit_test;

  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned DIGIT_COUNT  = 10;
  localparam int          RANDOM_COUNT = 320;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          CYCLE_LIMIT  = 400000;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic [VALUE_W-1:0]            in_value  = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [btda_pkg::CHAR_W-1:0]   out_digit_char;
  logic                          out_last;

  int error_count;
  int digits_pending;
  int numbers_taken;
  int digits_checked;
  int cycle_count  = 0;
  bit steady       = 1'b0;
  bit hold_request = 1'b0;

  binary_to_decimal_ascii_unit #(
    .INPUT_WIDTH(VALUE_W),
    .MAX_DIGITS (DIGIT_COUNT)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_digit_char(out_digit_char),
    .out_last      (out_last)
  );

  binary_to_decimal_ascii_unit_checker #(
    .INPUT_WIDTH(VALUE_W),
    .MAX_DIGITS (DIGIT_COUNT)
  ) digit_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_digit_char(out_digit_char),
    .out_last      (out_last),
    .error_count   (error_count),
    .digits_pending(digits_pending),
    .numbers_taken (numbers_taken),
    .digits_checked(digits_checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned power_of_ten(input int unsigned exponent);
    longint unsigned result;
    result = 1;
    for (int i = 0; i < exponent; i++) result = result * 10;
    return result;
  endfunction

  function automatic logic [VALUE_W-1:0] random_number();
    longint unsigned low;
    longint unsigned high;
    int unsigned     pick;
    int unsigned     length;
    pick = $urandom_range(99);
    if (pick < 45) begin
      length = $urandom_range(DIGIT_COUNT, 1);
      low    = (length == 1) ? 0 : power_of_ten(length - 1);
      high   = power_of_ten(length) - 1;
      if (high > 64'hFFFF_FFFF) high = 64'hFFFF_FFFF;
      return VALUE_W'($urandom_range(32'(high), 32'(low)));
    end else if (pick < 70) begin
      return VALUE_W'($urandom);
    end else if (pick < 82) begin
      return VALUE_W'($urandom_range(20));
    end else if (pick < 92) begin
      length = $urandom_range(DIGIT_COUNT - 1);
      return VALUE_W'(power_of_ten(length) + $urandom_range(2) - 1);
    end else begin
      return VALUE_W'(32'hFFFF_FFFF - $urandom_range(15));
    end
  endfunction

  // Holds the request until the unit takes it; random gaps come before it.
  task automatic send_number(input logic [VALUE_W-1:0] value);
    while (!steady && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      in_value <= VALUE_W'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 21);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles without finishing.", CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_number(32'd0);
    send_number(32'd1);
    send_number(32'd9);
    send_number(32'd7);
    send_number(32'd10);
    send_number(32'd42);
    send_number(32'd99);
    send_number(32'd100);
    send_number(32'd1000);
    send_number(32'd12345);
    send_number(32'd999999);
    send_number(32'd1000000);
    send_number(32'd98765432);
    send_number(32'd100000001);
    send_number(32'd999999999);
    send_number(32'd1000000000);
    send_number(32'd1000000001);
    send_number(32'd1020304050);
    send_number(32'd2147483647);
    send_number(32'd2147483648);
    send_number(32'd4000000000);
    send_number(32'd4294967294);
    send_number(32'd4294967295);

    hold_request = 1'b1;
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      steady = (n >= 120 && n < 180);
      send_number(random_number());
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    do @(negedge clk); while (digits_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d numbers into %0d checked digits, from zero to all ones.",
             numbers_taken, digits_checked);
    $display("Ran %0d cycles with random gaps, a %0d-cycle output hold-off and a gap-free stretch.",
             cycle_count, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== binary_to_decimal_ascii_unit.f =====
+incdir+hdl
hdl/btda_pkg.sv
hdl/btda_cell.sv
hdl/binary_to_decimal_ascii_unit.sv
sim/binary_to_decimal_ascii_unit_checker.sv
sim/binary_to_decimal_ascii_unit_test.sv
